// File: hw/rtl/assert_macros.svh
// assertion helpers, sampled on the rising edge of clock
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define BHT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define BHT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hw/rtl/bht_pkg.sv
package bht_pkg;

   localparam int KEY_W      = 32;
   localparam int VALUE_W    = 32;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 3;
   // key is reduced two bits per step
   localparam int HASH_STEPS = KEY_W / 2;

   localparam int DEF_NUM_BUCKETS  = 16;
   localparam int DEF_BUCKET_DEPTH = 8;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_UPDATED   = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_REMOVED   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd5;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  read_value;
      logic                table_empty;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } slot_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

// File: hw/rtl/bht_mod_unit.sv
module bht_mod_unit
   import bht_pkg::*;
#(
   parameter int NUM_BUCKETS = DEF_NUM_BUCKETS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [KEY_W-1:0]               key,
   output logic                           done,
   output logic [$clog2(NUM_BUCKETS)-1:0] rem
);

   localparam int REM_W  = $clog2(NUM_BUCKETS);
   localparam int WIDE_W = REM_W + 2;
   localparam int STEP_W = $clog2(HASH_STEPS);

   localparam logic [WIDE_W-1:0] MOD_1X = WIDE_W'(NUM_BUCKETS);
   localparam logic [WIDE_W-1:0] MOD_2X = WIDE_W'(2 * NUM_BUCKETS);
   localparam logic [WIDE_W-1:0] MOD_3X = WIDE_W'(3 * NUM_BUCKETS);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [WIDE_W-1:0] wide;

   // remainder so far times four plus the next two key bits, below four times the modulus
   assign wide = {rem_ff, key_ff[KEY_W-1 -: 2]};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      key_in  = key_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = STEP_W'(HASH_STEPS - 1);
         key_in  = key;
         rem_in  = '0;
      end else if (run_ff) begin
         if (wide >= MOD_3X) begin
            rem_in = REM_W'(wide - MOD_3X);
         end else if (wide >= MOD_2X) begin
            rem_in = REM_W'(wide - MOD_2X);
         end else if (wide >= MOD_1X) begin
            rem_in = REM_W'(wide - MOD_1X);
         end else begin
            rem_in = REM_W'(wide);
         end
         key_in  = {key_ff[KEY_W-3:0], 2'b00};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      key_ff  <= key_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

// File: hw/rtl/bucketed_hash_table_unit.sv
// Key-to-value table with NUM_BUCKETS buckets of BUCKET_DEPTH slots each; a key lives in
// bucket key mod NUM_BUCKETS. Pulse start while busy is low to hand over a command word
// (insert or update, remove, search). After reset the block runs a clearing pass over all
// NUM_BUCKETS*BUCKET_DEPTH slots and holds busy high meanwhile. For each command, the modulo unit
// reduces the key at two key bits per cycle, and the bucket scan reads one slot per cycle through
// the single read port of the slot memory, stopping early on a key match. The result word appears
// on rsp_data for exactly one cycle with rsp_strobe high, in the cycle busy drops; it cannot be
// stalled, so latch it then.
`include "assert_macros.svh"

module bucketed_hash_table_unit
   import bht_pkg::*;
#(
   parameter int NUM_BUCKETS  = DEF_NUM_BUCKETS,
   parameter int BUCKET_DEPTH = DEF_BUCKET_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int SLOT_TOTAL = NUM_BUCKETS * BUCKET_DEPTH;
   localparam int ADDR_W     = $clog2(SLOT_TOTAL);
   localparam int REM_W      = $clog2(NUM_BUCKETS);
   localparam int DCNT_W     = $clog2(BUCKET_DEPTH + 1);
   localparam int CNT_W      = $clog2(SLOT_TOTAL + 1);

   localparam logic [DCNT_W-1:0] DEPTH_END = DCNT_W'(BUCKET_DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SLOT_TOTAL - 1);

   slot_type mem [SLOT_TOTAL];

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [DCNT_W-1:0] idx_ff, idx_in;
   logic [DCNT_W-1:0] chk_idx_ff, chk_idx_in;
   logic              chk_ff, chk_in;
   logic              hit_ff, hit_in;
   logic [ADDR_W-1:0] hit_addr_ff, hit_addr_in;
   logic [VALUE_W-1:0] hit_value_ff, hit_value_in;
   logic              free_ff, free_in;
   logic [ADDR_W-1:0] free_addr_ff, free_addr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   slot_type          rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   slot_type          wr_data;
   logic [ADDR_W-1:0] chk_addr;
   logic              match;

   logic              mod_start;
   logic              mod_done;
   logic [REM_W-1:0]  mod_rem;

   bht_mod_unit #(
      .NUM_BUCKETS(NUM_BUCKETS)
   ) u_mod (
      .clock(clock),
      .reset(reset),
      .start(mod_start),
      .key  (req_data.key),
      .done (mod_done),
      .rem  (mod_rem)
   );

   assign rd_addr  = base_ff + ADDR_W'(idx_ff);
   assign chk_addr = base_ff + ADDR_W'(chk_idx_ff);
   // the one key comparator, reused for every slot of the bucket
   assign match    = chk_ff && rd_data_ff.valid && (rd_data_ff.key == req_ff.key);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      base_in       = base_ff;
      clr_addr_in   = clr_addr_ff;
      idx_in        = idx_ff;
      chk_idx_in    = chk_idx_ff;
      chk_in        = chk_ff;
      hit_in        = hit_ff;
      hit_addr_in   = hit_addr_ff;
      hit_value_in  = hit_value_ff;
      free_in       = free_ff;
      free_addr_in  = free_addr_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      mod_start     = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = clr_addr_ff;
      wr_data       = '0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_in    = req_data;
               mod_start = 1'b1;
               state_in  = ST_HASH;
            end
         end
         ST_HASH: begin
            if (mod_done) begin
               base_in  = ADDR_W'(mod_rem * BUCKET_DEPTH);
               idx_in   = '0;
               chk_in   = 1'b0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read data of the slot issued last cycle is checked while the next is issued
            if (match) begin
               hit_in       = 1'b1;
               hit_addr_in  = chk_addr;
               hit_value_in = rd_data_ff.value;
            end else if (chk_ff && !rd_data_ff.valid && !free_ff) begin
               free_in      = 1'b1;
               free_addr_in = chk_addr;
            end
            if (idx_ff != DEPTH_END) begin
               chk_in     = 1'b1;
               chk_idx_in = idx_ff;
               idx_in     = idx_ff + 1'b1;
            end else begin
               chk_in = 1'b0;
            end
            if (match || idx_ff == DEPTH_END) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            rsp_strobe_in          = 1'b1;
            rsp_data_in.status     = STAT_NOT_FOUND;
            rsp_data_in.read_value = '0;
            wr_data.key            = req_ff.key;
            wr_data.value          = req_ff.value;
            case (req_ff.command)
               CMD_INSERT: begin
                  wr_data.valid = 1'b1;
                  if (hit_ff) begin
                     wr_en              = 1'b1;
                     wr_addr            = hit_addr_ff;
                     rsp_data_in.status = STAT_UPDATED;
                  end else if (free_ff) begin
                     wr_en              = 1'b1;
                     wr_addr            = free_addr_ff;
                     count_in           = count_ff + 1'b1;
                     rsp_data_in.status = STAT_INSERTED;
                  end else begin
                     rsp_data_in.status = STAT_FULL;
                  end
               end
               CMD_REMOVE: begin
                  wr_data.valid = 1'b0;
                  if (hit_ff) begin
                     wr_en              = 1'b1;
                     wr_addr            = hit_addr_ff;
                     count_in           = count_ff - 1'b1;
                     rsp_data_in.status = STAT_REMOVED;
                  end
               end
               CMD_SEARCH: begin
                  if (hit_ff) begin
                     rsp_data_in.status     = STAT_FOUND;
                     rsp_data_in.read_value = hit_value_ff;
                  end
               end
               default: begin
                  rsp_data_in.status = STAT_NOT_FOUND;
               end
            endcase
            rsp_data_in.table_empty = (count_in == '0);
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         chk_ff        <= 1'b0;
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         chk_ff        <= chk_in;
         hit_ff        <= hit_in;
         free_ff       <= free_in;
      end
      req_ff       <= req_in;
      base_ff      <= base_in;
      idx_ff       <= idx_in;
      chk_idx_ff   <= chk_idx_in;
      hit_addr_ff  <= hit_addr_in;
      hit_value_ff <= hit_value_in;
      free_addr_ff <= free_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `BHT_ASSERT(a_finish_strobe, (state_ff == ST_FINISH) |=> rsp_strobe, "finish gave no result")
   `BHT_ASSERT(a_count_bound, count_ff <= CNT_W'(SLOT_TOTAL), "entry count above slot total")
   `BHT_ASSERT(a_empty_flag, rsp_strobe |-> rsp_data.table_empty == (count_ff == '0), "bad empty")
   `BHT_ASSERT(a_write_state, wr_en |-> state_ff == ST_CLEAR || state_ff == ST_FINISH, "bad write")
   `BHT_ASSERT_ALWAYS(a_reset_clear, $past(reset) |-> state_ff == ST_CLEAR, "no clear after reset")

endmodule
